FILE: src/bmpd_pkg.sv
// bmpd_pkg: shared types and constants for the bmp stream pixel decoder
// holds the command word passed from the parser to the pixel expander
// no dependencies
`timescale 1ns / 1ps

package bmpd_pkg;

    // default limits
    localparam int unsigned DEF_MAX_SIDE  = 4096;
    localparam int unsigned DEF_CMD_DEPTH = 4;
    localparam int unsigned COORD_LIMIT   = 4096;

    // field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIDE_W  = 13;
    localparam int unsigned COLOR_W = 8;

    // reset value of the size limit registers
    localparam logic [SIDE_W-1:0] MAX_SIDE_RESET = 13'd4096;

    // configuration register indexes
    localparam logic CFG_MAX_WIDTH  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NOT_BMP    = 2'd0;
    localparam logic [1:0] ERR_BAD_DEPTH  = 2'd1;
    localparam logic [1:0] ERR_COMPRESSED = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE  = 2'd3;

    // result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // command kinds between parser and expander
    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_ERR  = 2'd0;
    localparam t_cmd_kind CMD_RGB  = 2'd1;
    localparam t_cmd_kind CMD_MONO = 2'd2;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [1:0]           code;     // error code for error commands
        logic [COORD_W-1:0]   x;        // column, first column for mono
        logic [COORD_W-1:0]   y;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [7:0]           pattern;  // mono pixel bits, msb first
        logic [3:0]           nbits;    // mono pixel count, 1 to 8
    } t_cmd;

endpackage

FILE: src/bmpd_front.sv
// bmpd_front: byte parser of the bmp stream pixel decoder
// walks header, skip and pixel data phases and emits one command per productive word
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_front #(
    parameter int unsigned MAX_SIDE = bmpd_pkg::DEF_MAX_SIDE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_final_byte,
    input  logic [bmpd_pkg::SIDE_W-1:0]  i_max_width,
    input  logic [bmpd_pkg::SIDE_W-1:0]  i_max_height,
    output logic                         o_cmd_valid,
    output bmpd_pkg::t_cmd               o_cmd
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    logic [31:0] r_pos,    n_pos;
    logic [31:0] r_shift,  n_shift;
    logic [31:0] r_offset, n_offset;
    logic [12:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic        r_mono,   n_mono;
    logic [1:0]  r_phase,  n_phase;
    logic [11:0] r_col,    n_col;
    logic [11:0] r_row,    n_row;
    logic [15:0] r_held,   n_held;
    logic [1:0]  r_tri,    n_tri;
    logic [13:0] r_rbc,    n_rbc;

    logic [31:0] shift_new;
    logic [15:0] bpp;
    logic [12:0] y_full;
    logic [13:0] width_ext;
    logic [13:0] data_len;
    logic [13:0] row_len;
    logic [13:0] rbc_next;
    logic [12:0] col_ext;
    logic [12:0] col_rem;
    logic [12:0] row_next;

    function automatic logic [12:0] f_side_ok(input logic [31:0] v, input logic [12:0] lim);
        logic bad;
        bad = (v == 32'd0) || (v > {19'd0, lim}) || (v > 32'(MAX_SIDE))
            || (v > 32'(bmpd_pkg::COORD_LIMIT));
        return bad ? 13'd0 : v[12:0];
    endfunction

    assign shift_new = {i_data_byte, r_shift[31:8]};
    assign bpp       = shift_new[31:16];
    assign y_full    = r_height - 13'd1 - {1'b0, r_row};
    assign width_ext = {1'b0, r_width};
    assign data_len  = r_mono ? 14'((width_ext + 14'd7) >> 3) : 14'(width_ext + (width_ext << 1));
    assign row_len   = (data_len + 14'd3) & ~14'd3;
    assign rbc_next  = r_rbc + 14'd1;
    assign col_ext   = {1'b0, r_col};
    assign col_rem   = r_width - col_ext;
    assign row_next  = {1'b0, r_row} + 13'd1;

    always_comb begin
        n_pos = r_pos;       n_shift = r_shift;   n_offset = r_offset;
        n_width = r_width;   n_height = r_height; n_mono = r_mono;
        n_phase = r_phase;   n_col = r_col;       n_row = r_row;
        n_held = r_held;     n_tri = r_tri;       n_rbc = r_rbc;
        o_cmd_valid = 1'b0;
        o_cmd = '0;
        o_cmd.y = y_full[11:0];
        o_cmd.x = r_col;

        if (i_valid) begin
            n_pos = r_pos + 32'd1;
            case (r_phase)
                PH_HEADER: begin
                    n_shift = shift_new;
                    if ((r_pos == 32'd0 && i_data_byte != SIG_B) ||
                        (r_pos == 32'd1 && i_data_byte != SIG_M)) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = bmpd_pkg::CMD_ERR;
                        o_cmd.code  = bmpd_pkg::ERR_NOT_BMP;
                        n_phase     = PH_HALT;
                    end else begin
                        if (r_pos == 32'd13) n_offset = shift_new;
                        if (r_pos == 32'd21) n_width  = f_side_ok(shift_new, i_max_width);
                        if (r_pos == 32'd25) n_height = f_side_ok(shift_new, i_max_height);
                        if (r_pos == 32'd29) begin
                            if (bpp == 16'd1) begin
                                n_mono = 1'b1;
                            end else if (bpp == 16'd24) begin
                                n_mono = 1'b0;
                            end else begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = bmpd_pkg::CMD_ERR;
                                o_cmd.code  = bmpd_pkg::ERR_BAD_DEPTH;
                                n_phase     = PH_HALT;
                            end
                        end
                        if (r_pos == 32'd33) begin
                            if (shift_new != 32'd0) begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = bmpd_pkg::CMD_ERR;
                                o_cmd.code  = bmpd_pkg::ERR_COMPRESSED;
                                n_phase     = PH_HALT;
                            end else if (r_width == 13'd0 || r_height == 13'd0) begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = bmpd_pkg::CMD_ERR;
                                o_cmd.code  = bmpd_pkg::ERR_TOO_LARGE;
                                n_phase     = PH_HALT;
                            end else begin
                                n_phase = (r_offset > 32'd34) ? PH_SKIP : PH_PIXELS;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    if (({1'b0, r_pos} + 33'd1) >= {1'b0, r_offset}) n_phase = PH_PIXELS;
                end
                PH_PIXELS: begin
                    if (r_rbc < data_len) begin
                        if (r_mono) begin
                            if (col_ext < r_width) begin
                                o_cmd_valid   = 1'b1;
                                o_cmd.kind    = bmpd_pkg::CMD_MONO;
                                o_cmd.pattern = i_data_byte;
                                o_cmd.nbits   = (col_rem >= 13'd8) ? 4'd8 : col_rem[3:0];
                            end
                            n_col = r_col + 12'd8;
                        end else if (r_tri == 2'd0) begin
                            n_held = {8'd0, i_data_byte};
                            n_tri  = 2'd1;
                        end else if (r_tri == 2'd1) begin
                            n_held = {i_data_byte, r_held[7:0]};
                            n_tri  = 2'd2;
                        end else begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = bmpd_pkg::CMD_RGB;
                            o_cmd.red   = i_data_byte;
                            o_cmd.green = r_held[15:8];
                            o_cmd.blue  = r_held[7:0];
                            n_tri       = 2'd0;
                            n_col       = r_col + 12'd1;
                        end
                    end
                    n_rbc = rbc_next;
                    if (rbc_next >= row_len) begin
                        n_rbc = '0;
                        n_col = '0;
                        n_tri = '0;
                        if (row_next >= r_height) n_phase = PH_HALT;
                        else n_row = row_next[11:0];
                    end
                end
                default: begin
                    // halted: bytes are dropped until the final word
                end
            endcase

            if (i_final_byte) begin
                n_pos = '0;    n_shift = '0;  n_offset = '0;
                n_width = '0;  n_height = '0; n_mono = 1'b0;
                n_phase = PH_HEADER;
                n_col = '0;    n_row = '0;    n_held = '0;
                n_tri = '0;    n_rbc = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;    r_shift <= '0;  r_offset <= '0;
            r_width <= '0;  r_height <= '0; r_mono <= 1'b0;
            r_phase <= PH_HEADER;
            r_col <= '0;    r_row <= '0;    r_held <= '0;
            r_tri <= '0;    r_rbc <= '0;
        end else begin
            r_pos <= n_pos;       r_shift <= n_shift;   r_offset <= n_offset;
            r_width <= n_width;   r_height <= n_height; r_mono <= n_mono;
            r_phase <= n_phase;
            r_col <= n_col;       r_row <= n_row;       r_held <= n_held;
            r_tri <= n_tri;       r_rbc <= n_rbc;
        end
    end

endmodule

FILE: src/bmpd_cmd_fifo.sv
// bmpd_cmd_fifo: small command queue between parser and pixel expander
// register file with read and write pointers and an occupancy count
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_cmd_fifo #(
    parameter int unsigned DEPTH = bmpd_pkg::DEF_CMD_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmpd_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bmpd_pkg::t_cmd o_rdata
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    bmpd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
        if (i_pop)  n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
        if (i_push && !i_pop) n_count = r_count + CW'(1);
        else if (!i_push && i_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("command queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command popped from an empty queue");
`endif

endmodule

FILE: src/bmpd_back.sv
// bmpd_back: pixel expander of the bmp stream pixel decoder
// turns queued commands into result words in an output register, one a cycle while that register is free or popped
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  bmpd_pkg::t_cmd                 i_head,
    output logic                           o_head_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic                           o_result_kind,
    output logic [1:0]                     o_error_code,
    output logic [bmpd_pkg::COORD_W-1:0]   o_pixel_x,
    output logic [bmpd_pkg::COORD_W-1:0]   o_pixel_y,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_red,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_green,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_blue,
    output logic                           o_last_of_run
);

    logic        r_valid;
    logic [2:0]  r_sub, n_sub;
    logic        advance;
    logic        is_last;
    logic        mono_bit;
    logic [7:0]  mono_shifted;
    logic [7:0]  mono_val;

    logic                         n_kind;
    logic [1:0]                   n_code;
    logic [bmpd_pkg::COORD_W-1:0] n_x;
    logic [bmpd_pkg::COORD_W-1:0] n_y;
    logic [bmpd_pkg::COLOR_W-1:0] n_red;
    logic [bmpd_pkg::COLOR_W-1:0] n_green;
    logic [bmpd_pkg::COLOR_W-1:0] n_blue;

    logic                         r_kind;
    logic [1:0]                   r_code;
    logic [bmpd_pkg::COORD_W-1:0] r_x;
    logic [bmpd_pkg::COORD_W-1:0] r_y;
    logic [bmpd_pkg::COLOR_W-1:0] r_red;
    logic [bmpd_pkg::COLOR_W-1:0] r_green;
    logic [bmpd_pkg::COLOR_W-1:0] r_blue;
    logic                         r_last;

    assign advance      = i_head_valid && (!r_valid || i_pop);
    assign is_last      = (i_head.kind != bmpd_pkg::CMD_MONO) || ((4'(r_sub) + 4'd1) == i_head.nbits);
    assign mono_shifted = i_head.pattern << r_sub;
    assign mono_bit     = mono_shifted[7];
    assign mono_val     = mono_bit ? 8'hFF : 8'h00;
    assign o_head_pop   = advance && is_last;
    assign n_sub        = is_last ? 3'd0 : r_sub + 3'd1;

    always_comb begin
        n_kind  = bmpd_pkg::KIND_PIXEL;
        n_code  = '0;
        n_x     = i_head.x;
        n_y     = i_head.y;
        n_red   = i_head.red;
        n_green = i_head.green;
        n_blue  = i_head.blue;
        case (i_head.kind)
            bmpd_pkg::CMD_ERR: begin
                n_kind  = bmpd_pkg::KIND_ERROR;
                n_code  = i_head.code;
                n_x     = '0;
                n_y     = '0;
                n_red   = '0;
                n_green = '0;
                n_blue  = '0;
            end
            bmpd_pkg::CMD_MONO: begin
                n_x     = i_head.x + 12'(r_sub);
                n_red   = mono_val;
                n_green = mono_val;
                n_blue  = mono_val;
            end
            default: begin
                // rgb pixel passes straight through
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind  <= n_kind;
            r_code  <= n_code;
            r_x     <= n_x;
            r_y     <= n_y;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_sub   <= n_sub;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_valid;
    assign o_result_kind = r_kind;
    assign o_error_code  = r_code;
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_last_of_run = r_last;

`ifndef ASSERT_OFF
    a_sub_in_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 3'd0) |-> (i_head_valid && i_head.kind == bmpd_pkg::CMD_MONO
                             && {1'b0, r_sub} < i_head.nbits))
        else $error("mono pixel index outside its command");
`endif

endmodule

FILE: src/bmp_stream_pixel_decoder_core.sv
// bmp_stream_pixel_decoder_core: top level of the bmp stream pixel decoder
// wires the size limit registers, byte parser, command queue and pixel expander
// depends on bmpd_pkg, bmpd_front, bmpd_cmd_fifo, bmpd_back
`timescale 1ns / 1ps

// Decodes an uncompressed BMP file fed one byte per word on the push side
// and hands out results on the pop side, both with queue semantics. The
// parser checks the "BM" signature, takes the data offset, width, height,
// depth and compression from the little-endian header, skips to the pixel
// data and emits one pixel per BGR triple at 24 bits, or up to eight
// black/white pixels per byte at 1 bit, with bottom-up rows (first stored
// row has pixel_y = height-1). A bad signature, depth other than 1 or 24,
// nonzero compression, or a size of zero or above max_width / max_height /
// MAX_SIDE / 4096 gives one error result and the block ignores bytes until
// a word with final_byte set, which rearms it for a new file at any point.
// Rate: a byte is taken every cycle as long as the command queue has room.
// In 1-bit mode one byte makes up to eight results and the expander drives
// one result per cycle while results are popped; the CMD_DEPTH-entry queue
// absorbs bursts. A result goes through the command queue and the expander
// output register. No clearing pass after reset. The size limits are written
// through the cfg port (index 0 width, 1 height); the user must write them
// only while the block is idle, which it does not enforce; ready is always high.

module bmp_stream_pixel_decoder_core #(
    parameter int unsigned MAX_SIDE  = bmpd_pkg::DEF_MAX_SIDE,
    parameter int unsigned CMD_DEPTH = bmpd_pkg::DEF_CMD_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input, queue style
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_final_byte,
    // result output, queue style
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_result_kind,
    output logic [1:0]                     o_error_code,
    output logic [bmpd_pkg::COORD_W-1:0]   o_pixel_x,
    output logic [bmpd_pkg::COORD_W-1:0]   o_pixel_y,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_red,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_green,
    output logic [bmpd_pkg::COLOR_W-1:0]   o_blue,
    output logic                           o_last_of_run,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [bmpd_pkg::SIDE_W-1:0]    i_cfg_data
);

    // size limit registers
    logic [bmpd_pkg::SIDE_W-1:0] r_max_width;
    logic [bmpd_pkg::SIDE_W-1:0] r_max_height;

    // byte accepted this cycle
    logic           in_take;

    // parser to queue
    logic           cmd_valid;
    bmpd_pkg::t_cmd cmd;

    // queue to expander
    logic           q_empty;
    logic           q_pop;
    bmpd_pkg::t_cmd q_head;

    // result word leaves this cycle
    logic           out_take;

    assign o_cfg_ready = 1'b1;
    assign in_take     = push && !full;
    assign out_take    = pop && !empty;

    // config registers, written any time the channel handshakes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= bmpd_pkg::MAX_SIDE_RESET;
            r_max_height <= bmpd_pkg::MAX_SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmpd_pkg::CFG_MAX_WIDTH:  r_max_width  <= i_cfg_data;
                bmpd_pkg::CFG_MAX_HEIGHT: r_max_height <= i_cfg_data;
                default: begin
                    // no other registers
                end
            endcase
        end
    end

    // front: header parse, skip and pixel data classification
    bmpd_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_take),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_max_width  (r_max_width),
        .i_max_height (r_max_height),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    // queue lets the parser keep taking bytes while 1-bit bursts drain
    bmpd_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_wdata (cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_head)
    );

    // back: expands commands into result words
    bmpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (!q_empty),
        .i_head        (q_head),
        .o_head_pop    (q_pop),
        .i_pop         (out_take),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_error_code  (o_error_code),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last_of_run (o_last_of_run)
    );

endmodule
